>>> sv/spc_pkg.sv
// Shared constants and types for the set partition counter.
package spc_pkg;

    localparam int MAX_SET_SIZE = 32;
    localparam int MAX_PARTS    = 32;

    localparam int FIELD_W = 6;
    localparam int VAL_W   = 64;
    localparam int NCELLS  = MAX_PARTS + 1;
    localparam int COL_W   = $clog2(NCELLS);
    localparam int ROW_W   = $clog2(MAX_SET_SIZE + 1);
    localparam int PROD_W  = VAL_W + COL_W;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic load;   // start a new table: column 0 holds 1, the rest 0
        logic step;   // advance the whole row by one table row
    } t_cell_ctl;

endpackage

>>> sv/spc_cell.sv
// One column cell of the row: holds S(i,j) and its saturation flag.
module spc_cell
    import spc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [COL_W-1:0] i_col,
    input  logic [VAL_W-1:0] i_left_val,
    input  logic             i_left_sat,
    output logic [VAL_W-1:0] o_val,
    output logic             o_sat
);

    logic [VAL_W-1:0]  r_val;
    logic              r_sat;
    logic [PROD_W-1:0] w_prod;
    logic [VAL_W:0]    w_sum;
    logic              w_mul_ovf;
    logic              w_add_ovf;
    logic              n_sat;
    logic [VAL_W-1:0]  n_val;

    // S(i,j) = S(i-1,j-1) + j*S(i-1,j); the column number is a tied constant
    assign w_prod    = {{COL_W{1'b0}}, r_val} * {{VAL_W{1'b0}}, i_col};
    assign w_mul_ovf = |w_prod[PROD_W-1:VAL_W];
    assign w_sum     = {1'b0, i_left_val} + {1'b0, w_prod[VAL_W-1:0]};
    assign w_add_ovf = w_sum[VAL_W];

    always_comb begin
        n_sat = r_sat || i_left_sat || w_mul_ovf || w_add_ovf;
        n_val = n_sat ? {VAL_W{1'b1}} : w_sum[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_ctl.load) begin
            r_sat <= 1'b0;
        end else if (i_ctl.step) begin
            r_sat <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= (i_col == '0) ? VAL_W'(1) : '0;
        end else if (i_ctl.step) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

>>> sv/set_partition_count.sv
// Top level of the set partition counter: Stirling numbers of the second kind.
//
// Returns S(n,k), the number of ways to split n elements into k non-empty
// subsets, for n = i_set_size and k = i_part_count. A row of 33 column cells
// holds one row of the table; on each row step every cell takes its left
// neighbor's value and its own and forms the next row, walking down the
// table one row per cycle until row n is held. One item is in work at a
// time; o_in_stall stays high until the result is placed in the output
// register. Values saturate at all ones with o_overflowed set once the true
// count passes 64 bits, and a saturated cell taints every cell computed from
// it. S(0,0) is 1, S(n,0) and S(0,k) are 0 otherwise, k > n gives 0. A set
// size or part count above 32 gives 0 with o_overflowed clear.
module set_partition_count
    import spc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [FIELD_W-1:0] i_set_size,
    input  logic [FIELD_W-1:0] i_part_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VAL_W-1:0]   o_partition_count,
    output logic               o_overflowed
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic [ROW_W-1:0]   r_rows;
    logic [FIELD_W-1:0] r_k;
    logic               r_bad;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_val;
    logic               r_out_ovf;

    logic               w_accept;
    logic               w_bad;
    logic               w_out_free;
    t_cell_ctl          w_ctl;
    logic [VAL_W-1:0]   w_val  [NCELLS];
    logic               w_sat  [NCELLS];
    logic [VAL_W-1:0]   w_lval [NCELLS];
    logic               w_lsat [NCELLS];
    logic [VAL_W-1:0]   w_sel_val;
    logic               w_sel_sat;

    // Take a beat only when no item is in work
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_bad      = (int'(i_set_size) > MAX_SET_SIZE) ||
                        (int'(i_part_count) > MAX_PARTS);
    // Output register can take a result when empty or being drained
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Load the first row on accept, then advance one row per cycle
    assign w_ctl.load = w_accept;
    assign w_ctl.step = (r_state == ST_RUN);

    // Chain of column cells; column 0 sees an all-zero left neighbor
    for (genvar c = 0; c < NCELLS; c++) begin : g_cell
        if (c == 0) begin : g_edge
            assign w_lval[c] = '0;
            assign w_lsat[c] = 1'b0;
        end else begin : g_link
            assign w_lval[c] = w_val[c-1];
            assign w_lsat[c] = w_sat[c-1];
        end

        spc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_col      (COL_W'(c)),
            .i_left_val (w_lval[c]),
            .i_left_sat (w_lsat[c]),
            .o_val      (w_val[c]),
            .o_sat      (w_sat[c])
        );
    end

    // Pick column k out of the row with a one-hot and-or
    always_comb begin
        w_sel_val = '0;
        w_sel_sat = 1'b0;
        for (int c = 0; c < NCELLS; c++) begin
            if (int'(r_k) == c) begin
                w_sel_val = w_sel_val | w_val[c];
                w_sel_sat = w_sel_sat | w_sat[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise the result when the finished row is captured, drop it
            // once the beat is taken
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_k   <= i_part_count;
                        r_bad <= w_bad;
                        if (w_bad || i_set_size == '0) begin
                            r_rows  <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_rows  <= ROW_W'(i_set_size);
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_rows <= r_rows - ROW_W'(1);
                    if (r_rows == ROW_W'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold the finished row until the output register frees
                    if (w_out_free) begin
                        r_out_val   <= r_bad ? '0 : w_sel_val;
                        r_out_ovf   <= r_bad ? 1'b0 : w_sel_sat;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_partition_count = r_out_val;
    assign o_overflowed      = r_out_ovf;

`ifndef SYNTH
    // A saturated result always reads as all ones
    a_ovf_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflowed) |-> (&o_partition_count))
        else $error("overflowed result is not all ones");

    // Column 0 is zero after every row step
    a_col0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.step |=> (w_val[0] == '0 && !w_sat[0]))
        else $error("column 0 nonzero after a row step");

    // The row counter never runs dry while stepping
    a_rows_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rows != '0))
        else $error("stepping with no rows left");

    // A new result only comes out of the finishing state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the finishing state");
`endif

endmodule

>>> dv/spc_result_checker.sv
// Result checker for the set partition counter: predicts S(n,k) and compares.
module spc_result_checker
    import spc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [FIELD_W-1:0] i_set_size,
    input  logic [FIELD_W-1:0] i_part_count,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [VAL_W-1:0]   i_partition_count,
    input  logic               i_overflowed,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int WIDE_W = VAL_W + 8;

    typedef struct {
        logic [FIELD_W-1:0] set_size;
        logic [FIELD_W-1:0] part_count;
        logic [VAL_W-1:0]   partition_count;
        logic               overflowed;
    } t_partition_expect;

    t_partition_expect expected_counts[$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_counts.size();

    // Walk the table row by row, columns high to low, saturating sticky.
    function automatic t_partition_expect count_partitions(
        input logic [FIELD_W-1:0] n,
        input logic [FIELD_W-1:0] k
    );
        logic [VAL_W-1:0]  cells [NCELLS];
        logic              sat [NCELLS];
        logic [WIDE_W-1:0] wide;
        t_partition_expect r;
        r.set_size        = n;
        r.part_count      = k;
        r.partition_count = '0;
        r.overflowed      = 1'b0;
        if (n > MAX_SET_SIZE || k > MAX_PARTS)
            return r;
        for (int j = 0; j < NCELLS; j++) begin
            cells[j] = '0;
            sat[j]   = 1'b0;
        end
        cells[0] = 1;
        for (int i = 1; i <= int'(n); i++) begin
            for (int j = int'(k); j >= 1; j--) begin
                wide = WIDE_W'(cells[j]) * WIDE_W'(j) + WIDE_W'(cells[j-1]);
                if (sat[j-1] || sat[j] || wide[WIDE_W-1:VAL_W] != '0) begin
                    cells[j] = '1;
                    sat[j]   = 1'b1;
                end else begin
                    cells[j] = wide[VAL_W-1:0];
                end
            end
            cells[0] = '0;
            sat[0]   = 1'b0;
        end
        r.partition_count = cells[k];
        r.overflowed      = sat[k];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_partition_expect exp_beat;
        if (i_rst_n) begin
            // Retire the result beat first, then queue the new input beat.
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected (count %0h)",
                                              i_partition_count));
                end else begin
                    exp_beat = expected_counts.pop_front();
                    if (i_partition_count !== exp_beat.partition_count)
                        report_mismatch($sformatf("S(%0d,%0d) count %0h, expected %0h",
                                                  exp_beat.set_size, exp_beat.part_count,
                                                  i_partition_count,
                                                  exp_beat.partition_count));
                    if (i_overflowed !== exp_beat.overflowed)
                        report_mismatch($sformatf("S(%0d,%0d) overflow %b, expected %b",
                                                  exp_beat.set_size, exp_beat.part_count,
                                                  i_overflowed, exp_beat.overflowed));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_counts.push_back(count_partitions(i_set_size, i_part_count));
        end
    end

endmodule

>>> dv/tb.sv
// Testbench top for the set partition counter: stimulus, idling and verdict.
module tb;
    import spc_pkg::*;

    localparam int N_RANDOM     = 650;
    localparam int PHASE_LEN    = 230;   // random beats per idling phase
    localparam int HOLD_AT      = 100;   // beats sent before the long output hold
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [FIELD_W-1:0] i_set_size;
    logic [FIELD_W-1:0] i_part_count;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [VAL_W-1:0]   o_partition_count;
    logic               o_overflowed;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int tx_idle_pct = 37;
    int rx_idle_pct = 77;
    int cycle_count = 0;

    set_partition_count uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_set_size        (i_set_size),
        .i_part_count      (i_part_count),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_partition_count (o_partition_count),
        .o_overflowed      (o_overflowed)
    );

    spc_result_checker u_result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_set_size        (i_set_size),
        .i_part_count      (i_part_count),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_partition_count (o_partition_count),
        .i_overflowed      (o_overflowed),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Count cycles; end the run if it never drains.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one input beat after a random idle gap; return at the accepting edge.
    // Valid stays high into the next call unless that call idles first.
    task automatic offer_beat(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] k);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_set_size   <= n;
        i_part_count <= k;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    // Mostly legal queries, a band where values overflow, some out-of-table noise.
    task automatic offer_random_beat();
        int sel;
        int n;
        int k;
        sel = $urandom_range(99);
        if (sel < 10) begin
            n = $urandom_range(63);
            k = $urandom_range(63);
        end else if (sel < 25) begin
            n = $urandom_range(32, 20);
            k = $urandom_range(20, 4);
        end else begin
            n = $urandom_range(32);
            if (n > 0 && $urandom_range(99) < 70)
                k = $urandom_range(n, 1);
            else
                k = $urandom_range(32);
        end
        offer_beat(n[FIELD_W-1:0], k[FIELD_W-1:0]);
    endtask

    // Drive the output stall: random idling, plus one long hold that backs
    // the block up so it has to stall its input while beats keep coming.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_set_size   <= '0;
        i_part_count <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero sizes: only S(0,0) is one.
        offer_beat(6'd0, 6'd0);
        offer_beat(6'd0, 6'd5);
        offer_beat(6'd5, 6'd0);
        offer_beat(6'd0, 6'd32);
        // Table edges: first column and the diagonal are one.
        offer_beat(6'd1, 6'd1);
        offer_beat(6'd32, 6'd1);
        offer_beat(6'd32, 6'd32);
        offer_beat(6'd32, 6'd31);
        offer_beat(6'd10, 6'd3);
        offer_beat(6'd20, 6'd2);
        // More parts than elements gives zero.
        offer_beat(6'd3, 6'd5);
        offer_beat(6'd1, 6'd32);
        // Out of the table: zero result with the overflow flag clear.
        offer_beat(6'd33, 6'd1);
        offer_beat(6'd1, 6'd33);
        offer_beat(6'd63, 6'd63);
        offer_beat(6'd63, 6'd0);
        offer_beat(6'd0, 6'd63);
        offer_beat(6'd40, 6'd20);
        // Large middle of the table: saturation and its neighbors.
        offer_beat(6'd32, 6'd8);
        offer_beat(6'd32, 6'd10);
        offer_beat(6'd32, 6'd16);
        offer_beat(6'd32, 6'd20);
        offer_beat(6'd30, 6'd15);
        offer_beat(6'd28, 6'd14);

        // Random beats in three idling phases: sender light / receiver heavy,
        // then swapped, then back to back.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i < PHASE_LEN) begin
                tx_idle_pct = 37;
                rx_idle_pct = 77;
            end else if (i < 2 * PHASE_LEN) begin
                tx_idle_pct = 77;
                rx_idle_pct = 37;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            offer_random_beat();
        end
        i_in_valid <= 1'b0;

        // Let the last beat reach the checker, drain, then settle.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
